// ===== rtl/core/trmr_pkg.sv =====
package trmr_pkg;

	// field widths
	localparam int SMP_W  = 10;
	localparam int TICK_W = 8;
	localparam int DUTY_W = 10;
	localparam int SPAN_W = 5;
	// travel (10 bits) times span (at most 25) fits in 15 bits
	localparam int PROD_W = SMP_W + SPAN_W;
	localparam int CFG_AW = 5;
	localparam int APB_DW = 32;

	// duty constants
	localparam logic [DUTY_W-1:0] DUTY_STANDBY = 10'd24;
	localparam logic [DUTY_W-1:0] DUTY_RUN_MIN = 10'd31;
	localparam logic [DUTY_W-1:0] DUTY_MAX     = 10'd1023;
	localparam logic [SPAN_W-1:0] SPAN_FULL    = 5'd25;
	localparam logic [SPAN_W-1:0] SPAN_LIMITED = 5'd20;
	localparam logic [TICK_W-1:0] TICK_MAX     = 8'd255;

	// register indexes
	localparam logic [2:0] REG_SPEED_START = 3'd0;
	localparam logic [2:0] REG_SPEED_FULL  = 3'd1;
	localparam logic [2:0] REG_REV_TRIG    = 3'd2;
	localparam logic [2:0] REG_K1_LOW      = 3'd3;
	localparam logic [2:0] REG_K1_HIGH     = 3'd4;
	localparam logic [2:0] REG_K2_LOW      = 3'd5;
	localparam logic [2:0] REG_K2_HIGH     = 3'd6;
	localparam logic [2:0] REG_WAIT_TICKS  = 3'd7;

	// request types
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [SMP_W-1:0]  speed_sample;
		logic [SMP_W-1:0]  reverse_sample;
		logic [SMP_W-1:0]  key_one_sample;
		logic [SMP_W-1:0]  key_two_sample;
		logic              key_mode;
		logic              full_speed_select;
	} sample_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_value;
		logic              direction;
		logic              stopped;
	} result_t;

	typedef struct packed {
		logic [SMP_W-1:0]  speed_start_level;
		logic [SMP_W-1:0]  speed_full_level;
		logic [SMP_W-1:0]  reverse_trigger_level;
		logic [SMP_W-1:0]  key_one_low_level;
		logic [SMP_W-1:0]  key_one_high_level;
		logic [SMP_W-1:0]  key_two_low_level;
		logic [SMP_W-1:0]  key_two_high_level;
		logic [TICK_W-1:0] reverse_wait_ticks;
	} cfg_t;

endpackage

// ===== rtl/core/trmr_if.sv =====
interface trmr_sample_if import trmr_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface trmr_result_if import trmr_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/trmr_cfg.sv =====
module trmr_cfg import trmr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic       wr;
	logic [2:0] idx;
	cfg_t       cfg_q;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[CFG_AW-1:2];
	assign cfg    = cfg_q;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_start_level     <= 10'd461;
			cfg_q.speed_full_level      <= 10'd0;
			cfg_q.reverse_trigger_level <= 10'd205;
			cfg_q.key_one_low_level     <= 10'd358;
			cfg_q.key_one_high_level    <= 10'd154;
			cfg_q.key_two_low_level     <= 10'd358;
			cfg_q.key_two_high_level    <= 10'd154;
			cfg_q.reverse_wait_ticks    <= 8'd150;
		end else if (wr) begin
			case (idx)
				REG_SPEED_START: cfg_q.speed_start_level     <= pwdata[SMP_W-1:0];
				REG_SPEED_FULL:  cfg_q.speed_full_level      <= pwdata[SMP_W-1:0];
				REG_REV_TRIG:    cfg_q.reverse_trigger_level <= pwdata[SMP_W-1:0];
				REG_K1_LOW:      cfg_q.key_one_low_level     <= pwdata[SMP_W-1:0];
				REG_K1_HIGH:     cfg_q.key_one_high_level    <= pwdata[SMP_W-1:0];
				REG_K2_LOW:      cfg_q.key_two_low_level     <= pwdata[SMP_W-1:0];
				REG_K2_HIGH:     cfg_q.key_two_high_level    <= pwdata[SMP_W-1:0];
				REG_WAIT_TICKS:  cfg_q.reverse_wait_ticks    <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (idx)
			REG_SPEED_START: prdata[SMP_W-1:0]  = cfg_q.speed_start_level;
			REG_SPEED_FULL:  prdata[SMP_W-1:0]  = cfg_q.speed_full_level;
			REG_REV_TRIG:    prdata[SMP_W-1:0]  = cfg_q.reverse_trigger_level;
			REG_K1_LOW:      prdata[SMP_W-1:0]  = cfg_q.key_one_low_level;
			REG_K1_HIGH:     prdata[SMP_W-1:0]  = cfg_q.key_one_high_level;
			REG_K2_LOW:      prdata[SMP_W-1:0]  = cfg_q.key_two_low_level;
			REG_K2_HIGH:     prdata[SMP_W-1:0]  = cfg_q.key_two_high_level;
			REG_WAIT_TICKS:  prdata[TICK_W-1:0] = cfg_q.reverse_wait_ticks;
			default: prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/trmr_div.sv =====
module trmr_div import trmr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [SMP_W-1:0]  divisor,
	output logic              done,
	output logic [PROD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(PROD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SMP_W-1:0]  rem_q;
	logic [SMP_W-1:0]  dvs_q;
	logic [PROD_W-1:0] quo_q;
	logic [SMP_W+1:0]  trial;
	logic              fits;
	logic [SMP_W-1:0]  rem_next;

	// one quotient bit a cycle: shift the next dividend bit into the remainder
	assign trial    = {1'b0, rem_q, quo_q[PROD_W-1]} - {2'b00, dvs_q};
	assign fits     = !trial[SMP_W+1];
	assign rem_next = fits ? trial[SMP_W-1:0] : {rem_q[SMP_W-2:0], quo_q[PROD_W-1]};

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PROD_W);
				rem_q  <= '0;
				dvs_q  <= divisor;
				quo_q  <= dividend;
			end else if (busy_q) begin
				rem_q <= rem_next;
				quo_q <= {quo_q[PROD_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// checks
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("divider restarted while busy");
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q != CNT_W'(PROD_W) |-> rem_q < dvs_q)
		else $error("partial remainder not below divisor");

endmodule

// ===== rtl/core/trigger_motor_reversing_controller_unit.sv =====
// Channel  | Dir | Payload                                         | Handshake
// ---------+-----+-------------------------------------------------+--------------
// sample_ch| in  | req_type, four 10-bit readings, two mode pins    | valid/ready
// result_ch| out | duty_value, direction, stopped                   | valid/ready
// APB      | in  | eight registers at byte address 4*i              | pready high
//
// A tick, a sample that stops, or a sample that runs with start equal to full
// level is answered without the divider; a running sample is finished by the
// bit-serial divider (15 quotient bits).
// Reset (arst_n low) clears direction, stop flag and wait counter, sets duty 24.
// One finished result waits in a holding stage while the output register is
// stalled; input ready drops only while dividing or while that stage is full.
module trigger_motor_reversing_controller_unit import trmr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	trmr_sample_if.sink       sample_ch,
	trmr_result_if.source     result_ch
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	cfg_t              cfg;
	sample_t           s;
	logic              state_q;
	logic              dir_q;
	logic              stop_q;
	logic              neg_q;
	logic [TICK_W-1:0] wait_q;
	logic [DUTY_W-1:0] duty_q;
	result_t           res_q;
	logic              res_vld_q;
	result_t           out_q;
	logic              out_vld_q;

	logic              acc;
	logic              move;
	logic              left;
	logic              right;
	logic              wc_ok;
	logic [1:0]        ds;
	logic              run;
	logic [SMP_W-1:0]  travel;
	logic [SMP_W:0]    diff;
	logic              neg;
	logic [SMP_W-1:0]  mag;
	logic              zero_div;
	logic [PROD_W-1:0] prod;
	logic [DUTY_W-1:0] duty_zero;
	logic              div_start;
	logic              div_done;
	logic [PROD_W-1:0] quo;
	logic [PROD_W:0]   sum;
	logic [DUTY_W-1:0] duty_fin;

	// wanted direction against current {direction, stop}
	function automatic logic [1:0] want_dir(input logic [1:0] cur, input logic ok,
		input logic want);
		logic [1:0] nxt;
		nxt = cur;
		if (cur[1] == want)
			nxt[0] = 1'b0;
		else if (!cur[0])
			nxt[0] = 1'b1;
		else if (ok)
			nxt = {want, 1'b0};
		return nxt;
	endfunction

	trmr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign s               = sample_ch.data;
	assign sample_ch.ready = (state_q == ST_IDLE) && !res_vld_q;
	assign acc             = sample_ch.valid && sample_ch.ready;
	assign move            = res_vld_q && (!out_vld_q || result_ch.ready);
	assign result_ch.valid = out_vld_q;
	assign result_ch.data  = out_q;

	// key zones and direction request
	assign left  = (s.key_one_sample < cfg.key_one_high_level) &&
	               (s.key_two_sample > cfg.key_two_low_level);
	assign right = (s.key_one_sample > cfg.key_one_low_level) &&
	               (s.key_two_sample < cfg.key_two_high_level);
	assign wc_ok = wait_q >= cfg.reverse_wait_ticks;

	always_comb begin
		ds = {dir_q, stop_q};
		if (left || right) begin
			if (s.key_mode) begin
				if (right)
					ds = want_dir(ds, wc_ok, 1'b1);
				if (left)
					ds = want_dir(ds, wc_ok, 1'b0);
			end else begin
				ds = want_dir(ds, wc_ok, s.reverse_sample < cfg.reverse_trigger_level);
			end
		end else begin
			ds[0] = 1'b1;
		end
	end

	// duty operands: travel times span over |start - full|
	assign run       = (s.speed_sample <= cfg.speed_start_level) && !ds[0];
	assign travel    = cfg.speed_start_level - s.speed_sample;
	assign diff      = {1'b0, cfg.speed_start_level} - {1'b0, cfg.speed_full_level};
	assign neg       = diff[SMP_W];
	assign mag       = neg ? SMP_W'(-diff) : diff[SMP_W-1:0];
	assign zero_div  = cfg.speed_start_level == cfg.speed_full_level;
	assign prod      = s.full_speed_select ?
	                   ({1'b0, travel, 4'b0} + {2'b0, travel, 3'b0} + {5'b0, travel}) :
	                   ({1'b0, travel, 4'b0} + {3'b0, travel, 2'b0});
	assign duty_zero = DUTY_RUN_MIN +
	                   DUTY_W'(s.full_speed_select ? SPAN_FULL : SPAN_LIMITED);
	assign div_start = acc && (s.req_type == REQ_SAMPLE) && run && !zero_div;

	trmr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (mag),
		.done     (div_done),
		.quotient (quo)
	);

	// signed finish: clamp at zero below, saturate at full scale above
	assign sum = {1'b0, quo} + (PROD_W + 1)'(DUTY_RUN_MIN);
	always_comb begin
		if (neg_q)
			duty_fin = (quo > PROD_W'(DUTY_RUN_MIN)) ? '0 : DUTY_RUN_MIN - quo[DUTY_W-1:0];
		else if (sum > (PROD_W + 1)'(DUTY_MAX))
			duty_fin = DUTY_MAX;
		else
			duty_fin = sum[DUTY_W-1:0];
	end

	// control state, holding stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			dir_q     <= 1'b0;
			stop_q    <= 1'b0;
			neg_q     <= 1'b0;
			wait_q    <= '0;
			duty_q    <= DUTY_STANDBY;
			res_q     <= '0;
			res_vld_q <= 1'b0;
			out_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (move) begin
				out_q     <= res_q;
				out_vld_q <= 1'b1;
				res_vld_q <= 1'b0;
			end else if (result_ch.ready) begin
				out_vld_q <= 1'b0;
			end

			if (acc) begin
				if (s.req_type == REQ_TICK) begin
					if (wait_q != TICK_MAX)
						wait_q <= wait_q + 1'b1;
					res_q     <= '{duty_value: duty_q, direction: dir_q, stopped: stop_q};
					res_vld_q <= 1'b1;
				end else begin
					dir_q  <= ds[1];
					stop_q <= ds[0];
					if (run) begin
						wait_q <= '0;
						if (zero_div) begin
							duty_q    <= duty_zero;
							res_q     <= '{duty_value: duty_zero, direction: ds[1],
							               stopped: ds[0]};
							res_vld_q <= 1'b1;
						end else begin
							neg_q   <= neg;
							state_q <= ST_DIV;
						end
					end else begin
						duty_q    <= DUTY_STANDBY;
						res_q     <= '{duty_value: DUTY_STANDBY, direction: ds[1],
						               stopped: ds[0]};
						res_vld_q <= 1'b1;
					end
				end
			end

			if (state_q == ST_DIV && div_done) begin
				duty_q    <= duty_fin;
				res_q     <= '{duty_value: duty_fin, direction: dir_q, stopped: stop_q};
				res_vld_q <= 1'b1;
				state_q   <= ST_IDLE;
			end
		end
	end

	// checks
	a_tick_keeps_duty: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s.req_type == REQ_TICK |=> $stable(duty_q) && $stable(dir_q) && $stable(stop_q))
		else $error("tick changed duty or direction state");
	a_tick_counts: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s.req_type == REQ_TICK && wait_q != TICK_MAX |=> wait_q == $past(wait_q) + 1'b1)
		else $error("wait counter did not advance on tick");
	a_stopped_standby: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.stopped |-> out_q.duty_value == DUTY_STANDBY)
		else $error("stopped result with running duty");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV && !res_vld_q)
		else $error("division finished outside the divide state");

endmodule

// ===== sim/trmr_motor_checker.sv =====
`timescale 1ns / 1ps

// Watches the sample, result and register ports, keeps its own model of the
// controller and compares every result transaction with the oldest prediction.
module trmr_motor_checker import trmr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic              pready,
	trmr_sample_if            sample_mon,
	trmr_result_if            result_mon,
	output int                errors,
	output int                pending
);

	// model copy of the registers and controller state
	cfg_t              levels;
	logic              dir_q;
	logic              stop_q;
	logic [TICK_W-1:0] wait_q;
	logic [DUTY_W-1:0] duty_q;
	result_t           predicted_outputs[$];
	int                mismatch_cnt;

	// duty while running: minimum run duty plus scaled trigger travel, clamped
	function automatic logic [DUTY_W-1:0] run_duty(input logic [SMP_W-1:0] speed,
			input logic [SPAN_W-1:0] span);
		int start;
		int travel;
		int divisor;
		int duty;
		start   = int'(levels.speed_start_level);
		travel  = start - int'(speed);
		divisor = start - int'(levels.speed_full_level);
		// equal levels: whole span
		if (divisor == 0)
			duty = int'(DUTY_RUN_MIN) + int'(span);
		else
			duty = int'(DUTY_RUN_MIN) + (travel * int'(span)) / divisor;
		if (duty < 0)
			duty = 0;
		if (duty > int'(DUTY_MAX))
			duty = int'(DUTY_MAX);
		return DUTY_W'(duty);
	endfunction

	// direction request: stop first, flip only once the wait has elapsed
	task automatic steer_to(input logic want);
		if (dir_q == want) begin
			stop_q = 1'b0;
		end else if (!stop_q) begin
			stop_q = 1'b1;
		end else if (wait_q >= levels.reverse_wait_ticks) begin
			dir_q  = want;
			stop_q = 1'b0;
		end
	endtask

	// one input transaction through the model
	task automatic advance(input sample_t s, output result_t r);
		logic left;
		logic right;
		if (s.req_type == REQ_TICK) begin
			if (wait_q < TICK_MAX)
				wait_q = wait_q + 1'b1;
		end else begin
			left  = (s.key_one_sample < levels.key_one_high_level) &&
				(s.key_two_sample > levels.key_two_low_level);
			right = (s.key_one_sample > levels.key_one_low_level) &&
				(s.key_two_sample < levels.key_two_high_level);
			if (left || right) begin
				if (s.key_mode) begin
					// right first, then left, when both zones hold
					if (right)
						steer_to(1'b1);
					if (left)
						steer_to(1'b0);
				end else begin
					steer_to(s.reverse_sample < levels.reverse_trigger_level);
				end
			end else begin
				stop_q = 1'b1;
			end
			if (s.speed_sample <= levels.speed_start_level && !stop_q) begin
				wait_q = '0;
				duty_q = run_duty(s.speed_sample, s.full_speed_select ? SPAN_FULL : SPAN_LIMITED);
			end else begin
				duty_q = DUTY_STANDBY;
			end
		end
		r.duty_value = duty_q;
		r.direction  = dir_q;
		r.stopped    = stop_q;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t predicted;
		result_t got;
		if (!arst_n) begin
			levels.speed_start_level     = 10'd461;
			levels.speed_full_level      = 10'd0;
			levels.reverse_trigger_level = 10'd205;
			levels.key_one_low_level     = 10'd358;
			levels.key_one_high_level    = 10'd154;
			levels.key_two_low_level     = 10'd358;
			levels.key_two_high_level    = 10'd154;
			levels.reverse_wait_ticks    = 8'd150;
			dir_q        = 1'b0;
			stop_q       = 1'b0;
			wait_q       = '0;
			duty_q       = DUTY_STANDBY;
			mismatch_cnt = 0;
			predicted_outputs.delete();
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[CFG_AW-1:2])
					REG_SPEED_START: levels.speed_start_level     = pwdata[SMP_W-1:0];
					REG_SPEED_FULL:  levels.speed_full_level      = pwdata[SMP_W-1:0];
					REG_REV_TRIG:    levels.reverse_trigger_level = pwdata[SMP_W-1:0];
					REG_K1_LOW:      levels.key_one_low_level     = pwdata[SMP_W-1:0];
					REG_K1_HIGH:     levels.key_one_high_level    = pwdata[SMP_W-1:0];
					REG_K2_LOW:      levels.key_two_low_level     = pwdata[SMP_W-1:0];
					REG_K2_HIGH:     levels.key_two_high_level    = pwdata[SMP_W-1:0];
					REG_WAIT_TICKS:  levels.reverse_wait_ticks    = pwdata[TICK_W-1:0];
					default: ;
				endcase
			end
			// result side: compare with the oldest prediction
			if (result_mon.valid && result_mon.ready) begin
				got = result_mon.data;
				if (predicted_outputs.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: unexpected result duty %0d dir %0b stop %0b",
							$realtime, got.duty_value, got.direction, got.stopped);
				end else begin
					predicted = predicted_outputs.pop_front();
					if (got.duty_value !== predicted.duty_value ||
							got.direction !== predicted.direction ||
							got.stopped !== predicted.stopped) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("%0t: mismatch exp duty %0d dir %0b stop %0b, got duty %0d dir %0b stop %0b",
								$realtime, predicted.duty_value, predicted.direction,
								predicted.stopped, got.duty_value, got.direction, got.stopped);
					end
				end
			end
			// sample side: predict
			if (sample_mon.valid && sample_mon.ready) begin
				advance(sample_mon.data, predicted);
				predicted_outputs.push_back(predicted);
			end
		end
		errors  <= mismatch_cnt;
		pending <= predicted_outputs.size();
	end

endmodule

// ===== sim/trigger_motor_reversing_controller_unit_tb.sv =====
`timescale 1ns / 1ps

module trigger_motor_reversing_controller_unit_tb;
	import trmr_pkg::*;

	localparam int IDLE_LIMIT      = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 24;
	localparam int RANDOM_PHASES   = 12;
	localparam int PHASE_ITEMS     = 80;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	trmr_sample_if sample_ch ();
	trmr_result_if result_ch ();

	int   errors;
	int   pending;
	int   idle_cycles = 0;
	bit   tx_no_idle = 1'b0;
	bit   rx_no_idle = 1'b0;
	bit   hold_off_req = 1'b0;
	// sticky preferences so that direction requests repeat and flips complete
	bit   want_right = 1'b0;
	bit   key_pref = 1'b0;
	cfg_t cur_cfg;

	trigger_motor_reversing_controller_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.sample_ch(sample_ch),
		.result_ch(result_ch)
	);

	trmr_motor_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.sample_mon(sample_ch),
		.result_mon(result_ch),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog: cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
					(psel && penable)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic sample_t sample_of(input logic req, input int speed, input int rev,
			input int k1, input int k2, input logic mode, input logic fsel);
		sample_t s;
		s.req_type          = req;
		s.speed_sample      = SMP_W'(speed);
		s.reverse_sample    = SMP_W'(rev);
		s.key_one_sample    = SMP_W'(k1);
		s.key_two_sample    = SMP_W'(k2);
		s.key_mode          = mode;
		s.full_speed_select = fsel;
		return s;
	endfunction

	function automatic cfg_t cfg_of(input int start, input int full, input int rev,
			input int k1lo, input int k1hi, input int k2lo, input int k2hi, input int ticks);
		cfg_t c;
		c.speed_start_level     = SMP_W'(start);
		c.speed_full_level      = SMP_W'(full);
		c.reverse_trigger_level = SMP_W'(rev);
		c.key_one_low_level     = SMP_W'(k1lo);
		c.key_one_high_level    = SMP_W'(k1hi);
		c.key_two_low_level     = SMP_W'(k2lo);
		c.key_two_high_level    = SMP_W'(k2hi);
		c.reverse_wait_ticks    = TICK_W'(ticks);
		return c;
	endfunction

	// random levels, mostly with both key zones reachable and a short wait
	function automatic cfg_t rand_cfg();
		int start;
		int full;
		int pick;
		start = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(200, 1023);
		pick  = $urandom_range(0, 9);
		if (pick < 7)
			full = $urandom_range(0, start);
		else if (pick == 7)
			full = start;
		else
			full = $urandom_range(0, 1023);
		if ($urandom_range(0, 4) != 0)
			rand_cfg = cfg_of(start, full, $urandom_range(0, 1023), $urandom_range(256, 1022),
				$urandom_range(1, 511), $urandom_range(256, 1022), $urandom_range(1, 511), 0);
		else
			rand_cfg = cfg_of(start, full, $urandom_range(0, 1023), $urandom_range(0, 1023),
				$urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023), 0);
		rand_cfg.reverse_wait_ticks = ($urandom_range(0, 3) == 0) ?
			TICK_W'($urandom_range(0, 255)) : TICK_W'($urandom_range(0, 6));
	endfunction

	// random item: ticks, key-zone samples that follow a sticky request, and noise
	function automatic sample_t rand_item();
		int zone;
		int k1;
		int k2;
		int rev;
		int speed;
		int lvl;
		if ($urandom_range(0, 99) < 30)
			return sample_of(REQ_TICK, $urandom_range(0, 1023), $urandom_range(0, 1023),
				$urandom_range(0, 1023), $urandom_range(0, 1023), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		if ($urandom_range(0, 9) == 0)
			want_right = !want_right;
		if ($urandom_range(0, 19) == 0)
			key_pref = !key_pref;
		zone = $urandom_range(0, 9);
		k1 = $urandom_range(0, 1023);
		k2 = $urandom_range(0, 1023);
		if (zone < 8 && (want_right ^ (zone >= 6))) begin
			// right zone
			if (cur_cfg.key_one_low_level < 1023)
				k1 = $urandom_range(int'(cur_cfg.key_one_low_level) + 1, 1023);
			if (cur_cfg.key_two_high_level > 0)
				k2 = $urandom_range(0, int'(cur_cfg.key_two_high_level) - 1);
		end else if (zone < 8) begin
			// left zone
			if (cur_cfg.key_one_high_level > 0)
				k1 = $urandom_range(0, int'(cur_cfg.key_one_high_level) - 1);
			if (cur_cfg.key_two_low_level < 1023)
				k2 = $urandom_range(int'(cur_cfg.key_two_low_level) + 1, 1023);
		end
		lvl = int'(cur_cfg.reverse_trigger_level);
		if (zone == 9)
			rev = $urandom_range(0, 1023);
		else if (want_right && lvl > 0)
			rev = $urandom_range(0, lvl - 1);
		else
			rev = $urandom_range(lvl, 1023);
		speed = ($urandom_range(0, 3) != 0) ?
			$urandom_range(0, int'(cur_cfg.speed_start_level)) : $urandom_range(0, 1023);
		return sample_of(REQ_SAMPLE, speed, rev, k1, k2,
			(zone == 9) ? 1'($urandom_range(0, 1)) : key_pref, 1'($urandom_range(0, 1)));
	endfunction

	// register write: setup phase, access phase, then the bus returns to idle
	task automatic cfg_write(input logic [2:0] idx, input logic [APB_DW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_levels(input cfg_t c);
		cfg_write(REG_SPEED_START, APB_DW'(c.speed_start_level));
		cfg_write(REG_SPEED_FULL, APB_DW'(c.speed_full_level));
		cfg_write(REG_REV_TRIG, APB_DW'(c.reverse_trigger_level));
		cfg_write(REG_K1_LOW, APB_DW'(c.key_one_low_level));
		cfg_write(REG_K1_HIGH, APB_DW'(c.key_one_high_level));
		cfg_write(REG_K2_LOW, APB_DW'(c.key_two_low_level));
		cfg_write(REG_K2_HIGH, APB_DW'(c.key_two_high_level));
		cfg_write(REG_WAIT_TICKS, APB_DW'(c.reverse_wait_ticks));
		cur_cfg = c;
	endtask

	// offer one item after a random gap and wait for its transaction
	task automatic send_item(input sample_t item);
		int gap;
		gap = tx_no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.data  <= item;
		sample_ch.valid <= 1'b1;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	// stop offering and wait until every predicted result has come back
	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// opposite request, then a tick burst past saturation, then the flip
	task automatic tick_saturation(input bit right);
		sample_t s;
		s = right ? sample_of(REQ_SAMPLE, 1023, 0, 1023, 0, 1, 1) :
			sample_of(REQ_SAMPLE, 1023, 1023, 0, 1023, 1, 0);
		send_item(s);
		send_item(s);
		repeat (270)
			send_item(sample_of(REQ_TICK, $urandom_range(0, 1023), $urandom_range(0, 1023),
				$urandom_range(0, 1023), $urandom_range(0, 1023), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1))));
		send_item(s);
	endtask

	// result side: random stalls, and a long hold-off on request
	initial begin : result_sink
		int stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			stall = rx_no_idle ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
		end
	end

	initial begin : stimulus
		cfg_t c;
		arst_n          <= 1'b0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.data  <= '0;
		cur_cfg = cfg_of(461, 0, 205, 358, 154, 358, 154, 150);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: standby, run spans, stop on no key zone, both request sources
		program_levels(cfg_of(461, 0, 205, 358, 154, 358, 154, 2));
		send_item(sample_of(REQ_TICK, 1023, 1023, 1023, 1023, 1, 1));
		send_item(sample_of(REQ_SAMPLE, 0, 0, 500, 500, 0, 1));
		send_item(sample_of(REQ_SAMPLE, 0, 1023, 0, 1023, 0, 1));
		send_item(sample_of(REQ_SAMPLE, 0, 1023, 0, 1023, 0, 0));
		send_item(sample_of(REQ_SAMPLE, 461, 1023, 0, 1023, 0, 1));
		send_item(sample_of(REQ_SAMPLE, 462, 1023, 0, 1023, 0, 1));
		// key request for the other direction: stop, wait, flip
		send_item(sample_of(REQ_SAMPLE, 0, 1023, 1023, 0, 1, 1));
		send_item(sample_of(REQ_SAMPLE, 0, 1023, 1023, 0, 1, 1));
		send_item(sample_of(REQ_TICK, 0, 0, 0, 0, 0, 0));
		send_item(sample_of(REQ_TICK, 0, 0, 0, 0, 0, 0));
		send_item(sample_of(REQ_SAMPLE, 0, 1023, 1023, 0, 1, 1));
		// trigger requests
		send_item(sample_of(REQ_SAMPLE, 0, 0, 1023, 0, 0, 1));
		send_item(sample_of(REQ_SAMPLE, 0, 1023, 1023, 0, 0, 1));
		send_item(sample_of(REQ_TICK, 0, 0, 0, 0, 0, 0));
		send_item(sample_of(REQ_TICK, 0, 0, 0, 0, 0, 0));
		send_item(sample_of(REQ_SAMPLE, 0, 1023, 1023, 0, 0, 1));
		drain();
		// both zones at once, equal start and full level, no wait
		program_levels(cfg_of(600, 600, 1023, 0, 1023, 0, 1023, 0));
		send_item(sample_of(REQ_SAMPLE, 0, 0, 500, 500, 1, 1));
		send_item(sample_of(REQ_SAMPLE, 600, 0, 500, 500, 1, 1));
		send_item(sample_of(REQ_SAMPLE, 601, 0, 500, 500, 1, 1));
		send_item(sample_of(REQ_SAMPLE, 0, 0, 500, 500, 0, 1));
		send_item(sample_of(REQ_SAMPLE, 0, 0, 500, 500, 0, 1));
		drain();
		// full level above start: negative quotient clamps at zero
		program_levels(cfg_of(1000, 1001, 512, 0, 1023, 0, 1023, 255));
		send_item(sample_of(REQ_SAMPLE, 0, 0, 500, 500, 0, 0));
		drain();
		// divisor of one: duty saturates
		program_levels(cfg_of(1000, 999, 512, 0, 1023, 0, 1023, 255));
		send_item(sample_of(REQ_SAMPLE, 0, 0, 500, 500, 0, 1));
		drain();

		// random phases, each with its own levels
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0)
				c = cfg_of(0, 0, 0, 0, 0, 0, 0, 0);
			else if (p == 1)
				c = cfg_of(1023, 0, 512, 358, 154, 358, 154, 255);
			else if (p == 2)
				c = cfg_of(1023, 1023, 1023, 1023, 1023, 1023, 1023, 255);
			else
				c = rand_cfg();
			program_levels(c);
			tx_no_idle = (p == 3) || (p == 4);
			rx_no_idle = (p == 4);
			if (p == 3)
				hold_off_req = 1'b1;
			if (p == 1) begin
				tick_saturation(1'b1);
				tick_saturation(1'b0);
			end
			repeat (PHASE_ITEMS)
				send_item(rand_item());
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
